@@ src/sqrot_pkg.sv @@
package sqrot_pkg;

    localparam int MAX_SIDE = 8;
    localparam int SIDE_W   = 4;
    localparam int IDX_W    = 3;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;

    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] data_t;

    // Store write request from the load side.
    typedef struct packed {
        logic  en;
        addr_t addr;
        data_t data;
    } wr_t;

    // One complete matrix waiting to be drained.
    typedef struct packed {
        side_t side;
    } job_t;

    // A side of zero acts as one, anything above the maximum saturates.
    function automatic side_t eff_side(input side_t raw);
        side_t n;
        n = raw;
        if (n == '0) begin
            n = side_t'(1);
        end else if (n > side_t'(MAX_SIDE)) begin
            n = side_t'(MAX_SIDE);
        end
        return n;
    endfunction

endpackage

@@ src/sqrot_job_fifo.sv @@
module sqrot_job_fifo
    import sqrot_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic not_empty
);

    // Two-entry queue of completed matrices.
    job_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_job   = slot_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wp_next  = wp_reg + 1'b1;
        rp_next  = rp_reg + 1'b1;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wp_reg <= wp_next;
            end
            if (do_pop) begin
                rp_reg <= rp_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wp_reg] <= push_job;
        end
    end

endmodule

@@ src/sqrot_load.sv @@
module sqrot_load
    import sqrot_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  side_t side_cfg,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  data_t s_tdata,
    output wr_t   wr,
    output logic  push,
    output job_t  push_job,
    input  logic  fifo_full,
    input  logic  drain_done
);

    addr_t             load_count_reg, load_count_next;
    logic              pending_reg, pending_next;
    side_t             n;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  count_inc;
    logic              accept;
    logic              complete;

    assign n         = eff_side(side_cfg);
    assign total     = CNT_W'(n) * CNT_W'(n);
    assign count_inc = CNT_W'(load_count_reg) + CNT_W'(1);

    // The store is shared with the drain, so loading waits while a matrix is out.
    assign s_tready = !pending_reg && !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign complete = (count_inc >= total);

    assign wr.en         = accept;
    assign wr.addr       = load_count_reg;
    assign wr.data       = s_tdata;
    assign push          = accept && complete;
    assign push_job.side = n;

    always_comb begin
        load_count_next = load_count_reg;
        pending_next    = pending_reg;
        if (drain_done) begin
            pending_next = 1'b0;
        end
        if (accept) begin
            if (complete) begin
                load_count_next = '0;
                pending_next    = 1'b1;
            end else begin
                load_count_next = count_inc[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            pending_reg    <= 1'b0;
        end else begin
            load_count_reg <= load_count_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

@@ src/sqrot_drain.sv @@
module sqrot_drain
    import sqrot_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  wr_t   wr,
    input  logic  job_valid,
    input  job_t  job,
    output logic  job_pop,
    output logic  drain_done,
    output logic  busy,
    output logic  m_tvalid,
    input  logic  m_tready,
    output data_t m_tdata,
    output logic  m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    data_t  store_mem [DEPTH];

    state_t state_reg, state_next;
    side_t  side_reg, side_next;
    idx_t   i_reg, i_next;
    idx_t   j_reg, j_next;
    data_t  rd_data_reg;
    logic   valid_reg, valid_next;
    logic   last_reg;

    side_t  nm1;
    side_t  row;
    logic [2*SIDE_W-1:0] src;
    addr_t  rd_addr;
    logic   issue;
    logic   at_last;

    // out[i][j] comes from in[n-1-j][i].
    assign nm1     = side_reg - side_t'(1);
    assign row     = nm1 - side_t'(j_reg);
    assign src     = (2*SIDE_W)'(row) * (2*SIDE_W)'(side_reg) + (2*SIDE_W)'(i_reg);
    assign rd_addr = src[ADDR_W-1:0];
    assign at_last = (i_reg == nm1[IDX_W-1:0]) && (j_reg == nm1[IDX_W-1:0]);

    assign issue      = (state_reg == ST_RUN) && (!valid_reg || m_tready);
    assign job_pop    = (state_reg == ST_IDLE) && job_valid;
    assign drain_done = issue && at_last;
    assign busy       = (state_reg == ST_RUN);

    always_comb begin
        state_next = state_reg;
        side_next  = side_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_RUN;
                    side_next  = job.side;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    valid_next = 1'b1;
                    if (at_last) begin
                        state_next = ST_IDLE;
                    end else if (j_reg == nm1[IDX_W-1:0]) begin
                        j_next = '0;
                        i_next = i_reg + idx_t'(1);
                    end else begin
                        j_next = j_reg + idx_t'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        side_reg <= side_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        if (issue) begin
            rd_data_reg <= store_mem[rd_addr];
            last_reg    <= at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            store_mem[wr.addr] <= wr.data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = rd_data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ src/square_matrix_rotate_90_clockwise.sv @@
// Streams in an N by N matrix of signed 32-bit elements in row-major order, one
// element per input beat, and after the last element streams out the matrix
// rotated 90 degrees clockwise, again row-major, with tlast on the final element.
// N is set by the matrix side register (1 to 8; zero acts as 1, larger values
// act as 8) and should be written between matrices. The elements sit in a
// 64-entry store that has one write port and one read port; the drain reads one
// entry per cycle while the output is not stalled. Because the store holds one
// matrix, input is held off from the completing beat until the drain has read
// the last entry.
module square_matrix_rotate_90_clockwise
    import sqrot_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [3:0]  cfg_wdata,   // matrix_side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] element_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] element_out
    output logic        m_tlast      // last_of_matrix
);

    side_t side_reg;
    wr_t   wr;
    logic  push;
    job_t  push_job;
    logic  fifo_full;
    logic  job_valid;
    job_t  job;
    logic  job_pop;
    logic  drain_done;
    logic  drain_busy;

    // The side register powers up at the largest matrix.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= side_t'(MAX_SIDE);
        end else if (cfg_wen) begin
            side_reg <= cfg_wdata;
        end
    end

    // Front: counts incoming beats, writes the store and flags a full matrix.
    sqrot_load u_load (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .side_cfg   (side_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .wr         (wr),
        .push       (push),
        .push_job   (push_job),
        .fifo_full  (fifo_full),
        .drain_done (drain_done)
    );

    // Queue of complete matrices between the two halves.
    sqrot_job_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (fifo_full),
        .pop       (job_pop),
        .pop_job   (job),
        .not_empty (job_valid)
    );

    // Back: walks the rotated order, reads the store and drives the output.
    sqrot_drain u_drain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop),
        .drain_done (drain_done),
        .busy       (drain_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // No element may land in the store while the drain is still reading it.
    a_no_load_during_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !drain_busy)
        else $error("input beat accepted while the store is being drained");

    // At most one matrix is ever outstanding, so the queue never fills.
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_full)
        else $error("matrix queue overflow");

    // Once a matrix completes, input stays held off in the following cycle.
    a_hold_after_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> !s_tready)
        else $error("input not held off after a complete matrix");

endmodule

@@ test/square_matrix_rotate_90_clockwise_tb.sv @@
`timescale 1ns / 1ps

module square_matrix_rotate_90_clockwise_tb
    import sqrot_pkg::*;
();

    // Far above the slowest legal run: every beat waiting out the longest
    // source gap and the longest sink stall, plus the forced sink hold.
    localparam int CYCLE_LIMIT   = 400000;
    // Cycles to let the drain pipeline settle before touching the side register.
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 410;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        data_t value;
        logic  last;
    } rotated_elem_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // [31:0] element_in
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [31:0] element_out
    logic        m_tlast;            // last_of_matrix

    // Shadow copy of the block: element store, load counter and side register.
    data_t       loaded_elems [DEPTH];
    int unsigned load_cnt = 0;
    side_t       side_reg = side_t'(MAX_SIDE);

    // Rotated elements still owed by the block, oldest first.
    rotated_elem_t rotated_q [$];
    // Matrix elements waiting to be sent.
    data_t         pending_elems [$];

    bit src_gaps_on      = 1'b1;
    bit sink_stalls_on   = 1'b1;
    int sink_hold_cycles = 0;
    int src_gap_left     = 0;
    int sink_stall_left  = 0;
    int errors           = 0;
    int cycles           = 0;
    int random_items     = 0;

    square_matrix_rotate_90_clockwise u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // A side of zero behaves as one, and anything past the maximum is clamped.
    function automatic int side_in_use(side_t raw);
        if (raw == '0) begin
            return 1;
        end
        return (int'(raw) > MAX_SIDE) ? MAX_SIDE : int'(raw);
    endfunction

    // Most gaps are short; a few are long enough to starve the pipeline.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Mix of corner values, small signed values and fully random words.
    function automatic data_t pick_element();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end else if (r < 35) begin
            return data_t'($urandom_range(0, 31) - 16);
        end
        return $urandom;
    endfunction

    // Side choice for random phases: small matrices dominate so that many
    // complete matrices fit in the run; zero and oversized values are rarer.
    function automatic side_t pick_side();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return side_t'($urandom_range(9, 15));
        end else if (r < 8) begin
            return '0;
        end else if (r < 16) begin
            return side_t'($urandom_range(5, 8));
        end
        return side_t'($urandom_range(1, 4));
    endfunction

    // Number of beats that completes the matrix being loaded. If the side was lowered
    // mid-load so that at most one beat is left to go, the very next beat completes it.
    function automatic int items_to_complete();
        int total;
        total = side_in_use(side_reg) * side_in_use(side_reg);
        return (load_cnt + 1 >= total) ? 1 : total - int'(load_cnt);
    endfunction

    // Stores one accepted element. When the matrix completes, queues the whole
    // rotation: output (i, j) comes from input (n-1-j, i).
    task automatic load_element(data_t value);
        int n;
        int total;
        int src;
        rotated_elem_t e;
        n = side_in_use(side_reg);
        total = n * n;
        loaded_elems[load_cnt % DEPTH] = value;
        if (load_cnt + 1 < total) begin
            load_cnt = (load_cnt + 1) % 64;
        end else begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    src = ((n - 1 - j) * n + i) % DEPTH;
                    e.value = loaded_elems[src];
                    e.last = (i == n - 1) && (j == n - 1);
                    rotated_q.push_back(e);
                end
            end
            load_cnt = 0;
        end
    endtask

    // Register writes happen only while the block is idle, so the shadow side
    // can be updated right away. Ends on a falling edge so that queue updates
    // from the stimulus never share a time step with the driver.
    task automatic write_side(side_t value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        side_reg = value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) begin
            pending_elems.push_back(pick_element());
        end
        random_items += count;
    endtask

    // Waits until every element has been sent and every rotated element has
    // come back, then gives the drain logic time to go quiet.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_elems.size() != 0 || s_tvalid || rotated_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Source side: presents the next pending element, holds it until the beat
    // is taken, and inserts random gaps between beats while source gaps are on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                load_element(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap_left > 0) begin
                    src_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_elems.size() != 0) begin
                    s_tdata  <= pending_elems.pop_front();
                    s_tvalid <= 1'b1;
                    if (src_gaps_on) begin
                        src_gap_left = gap_len();
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks every result beat against the oldest expectation and
    // throttles tready, including the one long hold asked for by the stimulus.
    always @(posedge aclk) begin
        rotated_elem_t exp_elem;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rotated_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got data %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    exp_elem = rotated_q.pop_front();
                    if (m_tdata !== exp_elem.value) begin
                        errors++;
                        $display("%0t: element_out mismatch, expected %h, got %h",
                                 $time, exp_elem.value, m_tdata);
                    end
                    if (m_tlast !== exp_elem.last) begin
                        errors++;
                        $display("%0t: last_of_matrix mismatch, expected %b, got %b",
                                 $time, exp_elem.last, m_tlast);
                    end
                end
            end
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_tready <= 1'b0;
            end else if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (sink_stalls_on) begin
                    sink_stall_left = gap_len();
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int n;
        int total;
        int part;
        int matrices;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Side one: each beat is a complete matrix, sent with the word extremes.
        write_side(side_t'(1));
        pending_elems.push_back(32'h7FFF_FFFF);
        pending_elems.push_back(32'h8000_0000);
        pending_elems.push_back(32'h0000_0000);
        pending_elems.push_back(32'hFFFF_FFFF);
        wait_drained();

        // A side of zero must behave exactly like a side of one.
        write_side('0);
        pending_elems.push_back(32'h0000_0001);
        pending_elems.push_back(32'hFFFF_FFFE);
        wait_drained();

        // Two by two with the extremes in every position.
        write_side(side_t'(2));
        pending_elems.push_back(32'h8000_0000);
        pending_elems.push_back(32'h7FFF_FFFF);
        pending_elems.push_back(32'hFFFF_FFFF);
        pending_elems.push_back(32'h0000_0000);
        wait_drained();

        // Three by three with distinct values so that any index slip shows up.
        write_side(side_t'(3));
        for (int k = 0; k < 9; k++) begin
            pending_elems.push_back(data_t'(32'h100 + k));
        end
        wait_drained();

        // Side lowered mid-load: four elements into a three by three matrix,
        // then side two. The fifth beat completes a two by two rotation taken
        // from the first four store entries.
        for (int k = 0; k < 4; k++) begin
            pending_elems.push_back(data_t'(32'hA0 + k));
        end
        wait_drained();
        write_side(side_t'(2));
        pending_elems.push_back(32'h0000_00A4);
        wait_drained();

        // Long sink hold: the block completes a matrix, cannot drain it, and
        // has to push back on the source while more matrices are offered.
        write_side(side_t'(4));
        sink_hold_cycles = LONG_HOLD;
        queue_random(64);
        wait_drained();

        // Oversized side clamps to the maximum.
        write_side(side_t'(15));
        queue_random(64);
        wait_drained();

        // Random phases. Some run with no idling on one or both sides, and
        // some change the side in the middle of a matrix before finishing it.
        while (random_items < RANDOM_ITEMS) begin
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            write_side(pick_side());
            n = side_in_use(side_reg);
            total = n * n;
            if (total > 1 && $urandom_range(0, 4) == 0) begin
                part = $urandom_range(1, total - 1);
                queue_random(part);
                wait_drained();
                write_side(pick_side());
                queue_random(items_to_complete());
            end else begin
                matrices = (n >= 5) ? 1 : $urandom_range(1, 4);
                queue_random(matrices * total);
            end
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        if (rotated_q.size() != 0) begin
            errors++;
            $display("%0t: %0d rotated elements never arrived, expected none left, got %0d",
                     $time, rotated_q.size(), rotated_q.size());
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
